[src/pd4_pkg.sv]
// ----------------------------------------------------------------------------
// pd4_pkg
// Shared widths, register indexes and types of the four-lane point distance
// block.
// ----------------------------------------------------------------------------
package pd4_pkg;

    // coordinate format: signed fixed point, 8 fractional bits
    localparam int COORD_BITS = 16;
    localparam int LANES      = 4;
    localparam int NUM_FIELDS = 4;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;

    // difference, square, sum, then one root digit per stage
    localparam int FRONT_STAGES = 3;
    localparam int LAT          = FRONT_STAGES + ROOT_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Z = CFG_IDX_W'(2);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

endpackage

[src/point_distance_4lane.sv]
// ----------------------------------------------------------------------------
// point_distance_4lane
// Four-lane Euclidean distance of 3D points to a programmable reference point.
// ----------------------------------------------------------------------------
//  channel   ports                                  transfer when
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata       i_cfg_we high
//  points    start, busy, i_p0_x .. i_p3_z          start high and busy low
//  result    o_valid, o_dist0 .. o_dist3            o_valid high, one cycle
//
//  one batch of four points may enter every cycle while busy is low; its
//  distances pass three stages for difference, square and sum, then one
//  stage per root bit of the 17-bit square root pipeline
//  busy is high while reset is held and for the first cycle after it; reset
//  clears the reference point and drops all batches in flight
//  the receiver cannot stall, so nothing ever holds the pipeline
// ----------------------------------------------------------------------------
module point_distance_4lane (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic [pd4_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [pd4_pkg::COORD_BITS-1:0]         i_cfg_wdata,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p0_x,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p0_y,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p0_z,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p1_x,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p1_y,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p1_z,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p2_x,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p2_y,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p2_z,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p3_x,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p3_y,
    input  logic signed [pd4_pkg::COORD_BITS-1:0]  i_p3_z,
    output logic                                   o_valid,
    output logic [pd4_pkg::ROOT_W-1:0]             o_dist0,
    output logic [pd4_pkg::ROOT_W-1:0]             o_dist1,
    output logic [pd4_pkg::ROOT_W-1:0]             o_dist2,
    output logic [pd4_pkg::ROOT_W-1:0]             o_dist3
);

    pd4_pkg::t_point                r_ref, n_ref;
    logic                           r_rdy;
    logic [pd4_pkg::LAT-1:0]        r_vld;
    logic                           w_take;
    pd4_pkg::t_point                w_pt   [pd4_pkg::NUM_FIELDS];
    logic [pd4_pkg::ROOT_W-1:0]     w_dist [pd4_pkg::NUM_FIELDS];

    assign busy   = ~r_rdy;
    assign w_take = start & ~busy;

    always_comb begin
        n_ref = r_ref;
        unique case (i_cfg_idx)
            pd4_pkg::CFG_REF_X: n_ref.x = $signed(i_cfg_wdata);
            pd4_pkg::CFG_REF_Y: n_ref.y = $signed(i_cfg_wdata);
            pd4_pkg::CFG_REF_Z: n_ref.z = $signed(i_cfg_wdata);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
            r_rdy <= 1'b0;
            r_vld <= '0;
        end else begin
            r_rdy <= 1'b1;
            r_vld <= {r_vld[pd4_pkg::LAT-2:0], w_take};
            if (i_cfg_we) begin
                r_ref <= n_ref;
            end
        end
    end

    assign w_pt[0] = '{x: i_p0_x, y: i_p0_y, z: i_p0_z};
    assign w_pt[1] = '{x: i_p1_x, y: i_p1_y, z: i_p1_z};
    assign w_pt[2] = '{x: i_p2_x, y: i_p2_y, z: i_p2_z};
    assign w_pt[3] = '{x: i_p3_x, y: i_p3_y, z: i_p3_z};

    for (genvar l = 0; l < pd4_pkg::NUM_FIELDS; l++) begin : g_lane
        if (l < pd4_pkg::LANES) begin : g_used
            logic [pd4_pkg::SUM_W-1:0] w_sum;

            pd4_front u_front (
                .i_clk (i_clk),
                .i_ref (r_ref),
                .i_pt  (w_pt[l]),
                .o_sum (w_sum)
            );

            pd4_isqrt u_isqrt (
                .i_clk  (i_clk),
                .i_rad  (w_sum),
                .o_root (w_dist[l])
            );
        end else begin : g_unused
            assign w_dist[l] = '0;
        end
    end

    assign o_valid = r_vld[pd4_pkg::LAT-1];
    assign o_dist0 = w_dist[0];
    assign o_dist1 = w_dist[1];
    assign o_dist2 = w_dist[2];
    assign o_dist3 = w_dist[3];

    // a result strobe always matches a batch taken one latency earlier
    a_result_from_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_take, pd4_pkg::LAT))
        else $error("result strobe without a matching input transfer");

    // once r_rdy has been set after reset, the block is never busy
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");

    // writes to an unknown register index leave the reference untouched
    a_bad_index_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx != pd4_pkg::CFG_REF_X && i_cfg_idx != pd4_pkg::CFG_REF_Y
         && i_cfg_idx != pd4_pkg::CFG_REF_Z) |=> $stable(r_ref))
        else $error("reference changed by a write to an unknown index");

endmodule

[src/pd4_front.sv]
// ----------------------------------------------------------------------------
// pd4_front
// Squared distance of one point to the reference: difference, square and
// sum, one register stage each.
// ----------------------------------------------------------------------------
module pd4_front (
    input  logic                         i_clk,
    input  pd4_pkg::t_point              i_ref,
    input  pd4_pkg::t_point              i_pt,
    output logic [pd4_pkg::SUM_W-1:0]    o_sum
);

    logic signed [pd4_pkg::DIFF_W-1:0]   n_dx, n_dy, n_dz;
    logic signed [pd4_pkg::DIFF_W-1:0]   r_dx, r_dy, r_dz;
    logic signed [2*pd4_pkg::DIFF_W-1:0] w_px, w_py, w_pz;
    logic [pd4_pkg::SQ_W-1:0]            r_sqx, r_sqy, r_sqz;
    logic [pd4_pkg::SUM_W-1:0]           r_sum;

    always_comb begin
        n_dx = pd4_pkg::DIFF_W'(i_pt.x) - pd4_pkg::DIFF_W'(i_ref.x);
        n_dy = pd4_pkg::DIFF_W'(i_pt.y) - pd4_pkg::DIFF_W'(i_ref.y);
        n_dz = pd4_pkg::DIFF_W'(i_pt.z) - pd4_pkg::DIFF_W'(i_ref.z);
    end

    // signed squares are never negative and fit in SQ_W bits
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_dz  <= n_dz;
        r_sqx <= w_px[pd4_pkg::SQ_W-1:0];
        r_sqy <= w_py[pd4_pkg::SQ_W-1:0];
        r_sqz <= w_pz[pd4_pkg::SQ_W-1:0];
        r_sum <= pd4_pkg::SUM_W'(r_sqx) + pd4_pkg::SUM_W'(r_sqy)
               + pd4_pkg::SUM_W'(r_sqz);
    end

    assign o_sum = r_sum;

endmodule

[src/pd4_isqrt.sv]
// ----------------------------------------------------------------------------
// pd4_isqrt
// Pipelined floor square root, restoring digit recurrence, one root bit per
// register stage.
// ----------------------------------------------------------------------------
module pd4_isqrt (
    input  logic                          i_clk,
    input  logic [pd4_pkg::SUM_W-1:0]     i_rad,
    output logic [pd4_pkg::ROOT_W-1:0]    o_root
);

    logic [pd4_pkg::SUM_W-1:0]  w_n   [pd4_pkg::ROOT_W+1];
    logic [pd4_pkg::ROOT_W-1:0] w_q   [pd4_pkg::ROOT_W+1];
    logic [pd4_pkg::REM_W-1:0]  w_rem [pd4_pkg::ROOT_W+1];

    assign w_n[0]   = i_rad;
    assign w_q[0]   = '0;
    assign w_rem[0] = '0;

    for (genvar k = 0; k < pd4_pkg::ROOT_W; k++) begin : g_step
        logic [pd4_pkg::REM_W+1:0]  w_cur, w_trial, w_diff;
        logic                       w_ge;
        logic [pd4_pkg::SUM_W-1:0]  r_n;
        logic [pd4_pkg::ROOT_W-1:0] r_q;
        logic [pd4_pkg::REM_W-1:0]  r_rem;

        // bring down the next two radicand bits, try root*4 + 1
        assign w_cur   = {w_rem[k], w_n[k][pd4_pkg::SUM_W-1 -: 2]};
        assign w_trial = {1'b0, w_q[k], 2'b01};
        assign w_ge    = (w_cur >= w_trial);
        assign w_diff  = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            r_n   <= w_n[k] << 2;
            r_q   <= {w_q[k][pd4_pkg::ROOT_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[pd4_pkg::REM_W-1:0] : w_cur[pd4_pkg::REM_W-1:0];
        end

        assign w_n[k+1]   = r_n;
        assign w_q[k+1]   = r_q;
        assign w_rem[k+1] = r_rem;
    end

    assign o_root = w_q[pd4_pkg::ROOT_W];

endmodule
